// ----- src/ppv_pkg.sv -----
package ppv_pkg;

  // Command codes
  localparam logic [2:0] CMD_CLEAR       = 3'd0;
  localparam logic [2:0] CMD_LOAD_START  = 3'd1;
  localparam logic [2:0] CMD_LOAD_TARGET = 3'd2;
  localparam logic [2:0] CMD_ACTION      = 3'd3;
  localparam logic [2:0] CMD_FINISH      = 3'd4;

  // Step status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CONFLICT  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_FAILED    = 2'd3;

  localparam int POS_W = 10;

endpackage

// ----- src/pairing_pathway_validator.sv -----
// Channel  Direction  Handshake          Payload
// in       in         in_valid/in_stall  cmd, first_pos, second_pos
// out      out        out_valid/out_stall step_status, is_final, pathway_valid
//
// One transaction at a time; each takes one pass of a single scan sequencer
// over the partner memories, one entry read per cycle.
// Clear sweeps every entry. Load and action length is set by the crossing scan
// between first_pos and second_pos; finish compares the tables up to the first difference.
// Reset starts a clearing pass; in_stall is high during it.
// A result that is stalled on out holds the sequencer until it is taken.
module pairing_pathway_validator
  import ppv_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       cmd,
  input  logic [POS_W-1:0] first_pos,
  input  logic [POS_W-1:0] second_pos,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       step_status,
  output logic             is_final,
  output logic             pathway_valid
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] UNP  = PW'(MAX_LEN);
  localparam logic [PW-1:0] LAST = PW'(MAX_LEN - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RDF, S_RDS, S_CHK, S_SCAN, S_WR1, S_WR2, S_CMP, S_DONE
  } state_t;

  state_t        state;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] f_q, s_q, pf;
  logic          pend, tsel, is_act, do_add, clr_reply, failed;
  logic [1:0]    res_status;
  logic          res_final, res_valid;

  logic [PW-1:0] cur_mem [MAX_LEN];
  logic [PW-1:0] tgt_mem [MAX_LEN];
  logic [PW-1:0] cur_rd, tgt_rd, rdata;

  logic          cur_we, tgt_we;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;

  logic [CW-1:0] f_ext, s_ext;
  logic          pair_ok, accept, scan_hit;

  assign f_ext   = CW'(first_pos);
  assign s_ext   = CW'(second_pos);
  assign pair_ok = (f_ext < s_ext) && (s_ext < CW'(MAX_LEN));
  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign rdata   = tsel ? tgt_rd : cur_rd;
  assign scan_hit = pend && (rdata != UNP) && ((rdata < f_q) || (rdata > s_q));

  // Memory write port control
  always_comb begin
    cur_we  = 1'b0;
    tgt_we  = 1'b0;
    wr_addr = rd_addr[AW-1:0];
    wr_data = UNP;
    case (state)
      S_CLR: begin
        cur_we = 1'b1;
        tgt_we = 1'b1;
      end
      S_WR1: begin
        cur_we  = !tsel;
        tgt_we  = tsel;
        wr_addr = f_q[AW-1:0];
        wr_data = do_add ? s_q : UNP;
      end
      S_WR2: begin
        cur_we  = !tsel;
        tgt_we  = tsel;
        wr_addr = s_q[AW-1:0];
        wr_data = do_add ? f_q : UNP;
      end
      default: begin
      end
    endcase
  end

  // Partner memories, registered read
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[wr_addr] <= wr_data;
    cur_rd <= cur_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[wr_addr] <= wr_data;
    tgt_rd <= tgt_mem[rd_addr[AW-1:0]];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rd_addr   <= '0;
      clr_reply <= 1'b0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ST_OK;
            res_final  <= 1'b0;
            res_valid  <= 1'b0;
            f_q        <= f_ext[PW-1:0];
            s_q        <= s_ext[PW-1:0];
            rd_addr    <= f_ext[PW-1:0];
            tsel       <= 1'b0;
            is_act     <= 1'b0;
            case (cmd)
              CMD_CLEAR: begin
                failed    <= 1'b0;
                rd_addr   <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              CMD_LOAD_START, CMD_LOAD_TARGET: begin
                tsel <= (cmd == CMD_LOAD_TARGET);
                if (!pair_ok) begin
                  res_status <= ST_MALFORMED;
                  state      <= S_DONE;
                end else begin
                  state <= S_RDF;
                end
              end
              CMD_ACTION: begin
                is_act <= 1'b1;
                if (failed) begin
                  res_status <= ST_FAILED;
                  state      <= S_DONE;
                end else if (!pair_ok) begin
                  failed     <= 1'b1;
                  res_status <= ST_MALFORMED;
                  state      <= S_DONE;
                end else begin
                  state <= S_RDF;
                end
              end
              CMD_FINISH: begin
                res_final <= 1'b1;
                if (failed) begin
                  res_status <= ST_FAILED;
                  state      <= S_DONE;
                end else begin
                  rd_addr <= '0;
                  pend    <= 1'b0;
                  state   <= S_CMP;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // Clearing sweep over both tables
        S_CLR: begin
          if (rd_addr == LAST) begin
            res_status <= ST_OK;
            res_final  <= 1'b0;
            res_valid  <= 1'b0;
            clr_reply  <= 1'b0;
            state      <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            rd_addr <= rd_addr + PW'(1);
          end
        end
        S_RDF: begin
          rd_addr <= s_q;
          state   <= S_RDS;
        end
        S_RDS: begin
          pf    <= rdata;
          state <= S_CHK;
        end
        // Partner of first in pf, partner of second on rdata
        S_CHK: begin
          if (pf == s_q) begin
            do_add <= 1'b0;
            state  <= is_act ? S_WR1 : S_DONE;
          end else if (pf != UNP || rdata != UNP) begin
            res_status <= ST_CONFLICT;
            if (is_act) failed <= 1'b1;
            state <= S_DONE;
          end else begin
            do_add  <= 1'b1;
            rd_addr <= f_q + PW'(1);
            pend    <= 1'b0;
            state   <= S_SCAN;
          end
        end
        // Crossing scan over the open interval, one read in flight
        S_SCAN: begin
          if (scan_hit) begin
            res_status <= ST_CONFLICT;
            if (is_act) failed <= 1'b1;
            state <= S_DONE;
          end else if (rd_addr == s_q) begin
            state <= S_WR1;
          end else begin
            pend    <= 1'b1;
            rd_addr <= rd_addr + PW'(1);
          end
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_DONE;
        // Table compare for finish
        S_CMP: begin
          if (pend && (cur_rd != tgt_rd)) begin
            state <= S_DONE;
          end else if (rd_addr == UNP) begin
            res_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            pend    <= 1'b1;
            rd_addr <= rd_addr + PW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            step_status   <= res_status;
            is_final      <= res_final;
            pathway_valid <= res_valid;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ppv_checker.sv -----
module ppv_checker
  import ppv_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       step_status,
  input logic             is_final,
  input logic             pathway_valid
);

  // Reset starts the clearing pass
  a_rst_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // One transaction in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(step_status)
      && $stable(is_final) && $stable(pathway_valid)))
    else $error("stalled result changed");

  // Only a clean finish reports a valid pathway
  a_valid_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pathway_valid) |-> (is_final && step_status == ST_OK))
    else $error("pathway_valid outside clean finish");

endmodule

bind pairing_pathway_validator ppv_checker u_ppv_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .step_status(step_status),
  .is_final(is_final),
  .pathway_valid(pathway_valid)
);

// ----- tb/sv/pathway_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts each step result from its own copy of the
// partner tables and compares every result with the oldest prediction.
module pathway_checker
  import ppv_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       cmd,
  input  logic [POS_W-1:0] first_pos,
  input  logic [POS_W-1:0] second_pos,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       step_status,
  input  logic             is_final,
  input  logic             pathway_valid,
  output int               fail_count,
  output int               open_count
);

  localparam logic [10:0] NO_MATE = 11'(MAX_LEN);

  typedef struct packed {
    logic [1:0] status;
    logic       fin;
    logic       match;
  } step_result_t;

  // partner tables: entry i holds the mate of position i or NO_MATE
  logic [10:0]  cur_mate [MAX_LEN];
  logic [10:0]  tgt_mate [MAX_LEN];
  bit           pathway_broken;
  step_result_t pending_steps [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void wipe_tables();
    for (int i = 0; i < MAX_LEN; i++) begin
      cur_mate[i] = NO_MATE;
      tgt_mate[i] = NO_MATE;
    end
    pathway_broken = 1'b0;
  endfunction

  function automatic logic [10:0] mate_of(input bit in_goal, input int pos);
    return in_goal ? tgt_mate[pos] : cur_mate[pos];
  endfunction

  function automatic bit well_formed(input int f, input int s);
    return (f < s) && (s < MAX_LEN);
  endfunction

  // shares an end with, or crosses, a pair already in the table
  function automatic bit blocked(input bit in_goal, input int f, input int s);
    int m;
    if (mate_of(in_goal, f) != NO_MATE || mate_of(in_goal, s) != NO_MATE) return 1'b1;
    for (int i = f + 1; i < s; i++) begin
      m = int'(mate_of(in_goal, i));
      if (m != MAX_LEN && (m < f || m > s)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void pair_up(input bit in_goal, input int f, input int s);
    if (in_goal) begin
      tgt_mate[f] = 11'(s);
      tgt_mate[s] = 11'(f);
    end else begin
      cur_mate[f] = 11'(s);
      cur_mate[s] = 11'(f);
    end
  endfunction

  function automatic logic [1:0] load_pair(input bit in_goal, input int f, input int s);
    if (!well_formed(f, s)) return ST_MALFORMED;
    if (int'(mate_of(in_goal, f)) == s) return ST_OK;
    if (blocked(in_goal, f, s)) return ST_CONFLICT;
    pair_up(in_goal, f, s);
    return ST_OK;
  endfunction

  // next state of the tables and the result of one command
  function automatic step_result_t apply_command(input logic [2:0] c, input int f,
                                                 input int s);
    step_result_t r;
    r = '0;
    case (c)
      CMD_CLEAR: wipe_tables();
      CMD_LOAD_START: r.status = load_pair(1'b0, f, s);
      CMD_LOAD_TARGET: r.status = load_pair(1'b1, f, s);
      CMD_ACTION: begin
        if (pathway_broken) begin
          r.status = ST_FAILED;
        end else if (!well_formed(f, s)) begin
          pathway_broken = 1'b1;
          r.status = ST_MALFORMED;
        end else if (int'(cur_mate[f]) == s) begin
          cur_mate[f] = NO_MATE;
          cur_mate[s] = NO_MATE;
        end else if (blocked(1'b0, f, s)) begin
          pathway_broken = 1'b1;
          r.status = ST_CONFLICT;
        end else begin
          pair_up(1'b0, f, s);
        end
      end
      CMD_FINISH: begin
        r.fin = 1'b1;
        if (pathway_broken) begin
          r.status = ST_FAILED;
        end else begin
          r.match = 1'b1;
          for (int i = 0; i < MAX_LEN; i++)
            if (cur_mate[i] != tgt_mate[i]) r.match = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result side first, so a result never meets the transaction accepted with it
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      wipe_tables();
      pending_steps.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_steps.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = pending_steps.pop_front();
          if (step_status != want.status || is_final != want.fin ||
              pathway_valid != want.match)
            report_mismatch($sformatf(
              "got status %0d final %0d valid %0d, wanted %0d %0d %0d",
              step_status, is_final, pathway_valid, want.status, want.fin,
              want.match));
        end
      end
      if (in_valid && !in_stall)
        pending_steps = {pending_steps,
                         apply_command(cmd, int'(first_pos), int'(second_pos))};
    end
    open_count = pending_steps.size();
  end

endmodule

// ----- tb/sv/tb_pairing_pathway_validator.sv -----
`timescale 1ns / 1ps

module tb_pairing_pathway_validator;
  import ppv_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam int ITEM_GOAL = 580;
  localparam int HOLD_CYCLES = 400;
  // codes the block does not decode
  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       cmd = CMD_CLEAR;
  logic [POS_W-1:0] first_pos = '0;
  logic [POS_W-1:0] second_pos = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       step_status;
  logic             is_final;
  logic             pathway_valid;
  int               fail_count;
  int               open_count;

  int offered = 0;
  int taken = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  // pair lists used to build pathways
  int walk_lo [$];
  int walk_hi [$];
  int goal_lo [$];
  int goal_hi [$];
  int start_lo [$];
  int start_hi [$];
  int act_lo [$];
  int act_hi [$];

  pairing_pathway_validator #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .first_pos(first_pos), .second_pos(second_pos),
    .out_valid(out_valid), .out_stall(out_stall),
    .step_status(step_status), .is_final(is_final), .pathway_valid(pathway_valid)
  );

  pathway_checker #(.MAX_LEN(MAX_LEN)) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .first_pos(first_pos), .second_pos(second_pos),
    .out_valid(out_valid), .out_stall(out_stall),
    .step_status(step_status), .is_final(is_final), .pathway_valid(pathway_valid),
    .fail_count(fail_count), .open_count(open_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // one input transaction, after a random gap; stall is sampled at the falling edge
  task automatic offer(input logic [2:0] c, input int f, input int s);
    int gap;
    bit held;
    if (offered % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    first_pos  <= POS_W'(f);
    second_pos <= POS_W'(s);
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    offered++;
  endtask

  function automatic bit holds(input int los[$], input int his[$], input int lo,
                               input int hi);
    for (int k = 0; k < los.size(); k++)
      if (los[k] == lo && his[k] == hi) return 1'b1;
    return 1'b0;
  endfunction

  // random non-crossing pair set over a window, from a bracket walk
  task automatic make_structure(input int base, input int width);
    int open_pos [$];
    walk_lo.delete();
    walk_hi.delete();
    for (int p = base; p < base + width; p++) begin
      case ($urandom_range(0, 2))
        0: open_pos = {open_pos, p};
        1: begin
          if (open_pos.size() > 0) begin
            walk_lo = {walk_lo, open_pos.pop_back()};
            walk_hi = {walk_hi, p};
          end
        end
        default: ;
      endcase
    end
  endtask

  // random item: any command, mostly short spans
  task automatic offer_noise();
    int f;
    int s;
    f = $urandom_range(0, MAX_LEN - 1);
    if ($urandom_range(0, 7) == 0) s = $urandom_range(0, MAX_LEN - 1);
    else s = (f + $urandom_range(0, 12)) % MAX_LEN;
    offer(3'($urandom_range(0, 7)), f, s);
  endtask

  // clear, load target and start sets, walk from start to target, finish
  task automatic run_pathway();
    int width;
    int base;
    int flaw;
    int skip_at;
    bit adding;
    width = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 200) : $urandom_range(4, 40);
    base = $urandom_range(0, MAX_LEN - width);
    flaw = $urandom_range(0, 9);
    offer(CMD_CLEAR, $urandom_range(0, MAX_LEN - 1), $urandom_range(0, MAX_LEN - 1));
    make_structure(base, width);
    goal_lo = walk_lo;
    goal_hi = walk_hi;
    make_structure(base, width);
    start_lo = walk_lo;
    start_hi = walk_hi;
    for (int k = 0; k < goal_lo.size(); k++) offer(CMD_LOAD_TARGET, goal_lo[k], goal_hi[k]);
    for (int k = 0; k < start_lo.size(); k++) offer(CMD_LOAD_START, start_lo[k], start_hi[k]);

    // repeated load, reversed load, early finish
    if (flaw == 7) begin
      if (start_lo.size() > 0) offer(CMD_LOAD_START, start_lo[0], start_hi[0]);
      offer(CMD_LOAD_TARGET, base + width - 1, base);
      offer(CMD_FINISH, base, base + width - 1);
    end

    // removals of start-only pairs, then adds of target-only pairs (swapped on one flaw)
    act_lo.delete();
    act_hi.delete();
    for (int pass = 0; pass < 2; pass++) begin
      adding = ((pass == 0) == (flaw == 8));
      if (adding) begin
        for (int k = 0; k < goal_lo.size(); k++)
          if (!holds(start_lo, start_hi, goal_lo[k], goal_hi[k])) begin
            act_lo = {act_lo, goal_lo[k]};
            act_hi = {act_hi, goal_hi[k]};
          end
      end else begin
        for (int k = 0; k < start_lo.size(); k++)
          if (!holds(goal_lo, goal_hi, start_lo[k], start_hi[k])) begin
            act_lo = {act_lo, start_lo[k]};
            act_hi = {act_hi, start_hi[k]};
          end
      end
    end

    skip_at = (flaw == 6) ? $urandom_range(0, act_lo.size()) : -1;
    for (int k = 0; k < act_lo.size(); k++) begin
      if (flaw == 9 && k == act_lo.size() / 2)
        offer(CMD_ACTION, base + $urandom_range(0, width - 1),
              base + $urandom_range(0, width - 1));
      if (k != skip_at) offer(CMD_ACTION, act_lo[k], act_hi[k]);
    end
    offer(CMD_FINISH, $urandom_range(0, MAX_LEN - 1), $urandom_range(0, MAX_LEN - 1));
  endtask

  // result side: random stall before each transaction, two long hold-offs
  initial begin
    int hold;
    bit ready;
    wait (rst == 1'b0);
    forever begin
      if (taken % 50 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      hold = receiver_calm ? 0 : $urandom_range(0, 6);
      if (taken == 60 || taken == 350) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        ready = out_valid;
        @(posedge clk);
      end while (!ready);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    offer(CMD_FINISH, 0, 0);              // empty tables agree
    offer(CMD_LOAD_START, 0, MAX_LEN - 1); // widest pair
    offer(CMD_LOAD_TARGET, 0, MAX_LEN - 1);
    offer(CMD_LOAD_START, 0, MAX_LEN - 1); // already stored
    offer(CMD_LOAD_START, 1, MAX_LEN - 1); // shares an end
    offer(CMD_LOAD_TARGET, 5, 5);         // equal ends
    offer(CMD_LOAD_START, MAX_LEN - 1, 0); // reversed ends
    offer(CMD_FINISH, 0, 0);
    offer(CMD_ACTION, 0, MAX_LEN - 1);    // removal
    offer(CMD_LOAD_START, 10, 20);
    offer(CMD_LOAD_START, 15, 30);        // crossing load
    offer(CMD_ACTION, 12, 18);            // nested add
    offer(CMD_FINISH, 0, 0);              // tables differ
    offer(CMD_ACTION, 15, 30);            // crossing action fails the pathway
    offer(CMD_ACTION, 12, 18);            // ignored once failed
    offer(CMD_LOAD_TARGET, 100, 200);     // loads still work once failed
    offer(CMD_FINISH, 0, 0);
    offer(CMD_UNDEF_LO, MAX_LEN - 1, MAX_LEN - 1);
    offer(CMD_UNDEF_HI, 0, 0);
    offer(CMD_CLEAR, 0, 0);
    offer(CMD_ACTION, 9, 9);              // malformed action fails
    offer(CMD_FINISH, 0, 0);
    offer(CMD_CLEAR, MAX_LEN - 1, MAX_LEN - 1);
    offer(CMD_ACTION, MAX_LEN - 2, MAX_LEN - 1);
    offer(CMD_ACTION, MAX_LEN - 3, MAX_LEN - 2); // shared end on an action

    while (offered < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) offer_noise();
      else run_pathway();
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (open_count != 0);
    repeat (MAX_LEN + 16) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ppv_pkg.sv
src/pairing_pathway_validator.sv
src/ppv_checker.sv
tb/sv/pathway_checker.sv
tb/sv/tb_pairing_pathway_validator.sv
